/* rtl/core/lph_pkg.sv */
// shared constants and codes for the linear probing hash table
package lph_pkg;

  localparam int TABLE_SIZE_DEF = 1024;
  localparam int KEY_BITS_DEF   = 20;
  localparam int VALUE_BITS     = 32;
  localparam int OPCODE_BITS    = 2;
  localparam int STATUS_BITS    = 2;
  localparam int SLOT_BITS      = 2;

  localparam logic [OPCODE_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_SEARCH = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_BITS-1:0] RES_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [STATUS_BITS-1:0] RES_FULL      = 2'd2;

  localparam logic [SLOT_BITS-1:0] SL_EMPTY    = 2'd0;
  localparam logic [SLOT_BITS-1:0] SL_OCCUPIED = 2'd1;
  localparam logic [SLOT_BITS-1:0] SL_DELETED  = 2'd2;

endpackage

/* rtl/core/linear_probe_hash_table.sv */
// linear probing hash table top level: probe sequencer, slot memories, fill count
// sequence: input beat, hash step, then a read and a compare step per probed slot, then
//   the output load; a table not a power of two adds the reciprocal modulo reduction
// items are taken one at a time; a refused insert or unknown opcode skips hashing and probing
// each probe is a read step of the status and key/value memories followed by a compare step
// reset: a clearing sweep writes every status entry empty; no input is taken until it ends
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [OPCODE_BITS-1:0]       opcode,
  input  logic [KEY_BITS-1:0]          lookup_key,
  input  logic signed [VALUE_BITS-1:0] new_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [STATUS_BITS-1:0]       status,
  output logic signed [VALUE_BITS-1:0] read_value
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int KV_W  = KEY_BITS + VALUE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(TABLE_SIZE);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                   state;
  logic [2:0]                   state_next;
  logic [OPCODE_BITS-1:0]       op;
  logic [KEY_BITS-1:0]          key;
  logic signed [VALUE_BITS-1:0] val;
  logic [IDX_W-1:0]             idx;
  logic [IDX_W-1:0]             probe_cnt;
  logic [IDX_W-1:0]             clr_idx;
  logic [CNT_W-1:0]             fill;
  logic [STATUS_BITS-1:0]       res_status;
  logic signed [VALUE_BITS-1:0] res_value;

  logic                         in_beat;
  logic                         home_start;
  logic                         home_done;
  logic [IDX_W-1:0]             home_idx;

  logic                         st_we;
  logic [IDX_W-1:0]             st_waddr;
  logic [SLOT_BITS-1:0]         st_wdata;
  logic [SLOT_BITS-1:0]         st_rdata;
  logic                         kv_we;
  logic [KV_W-1:0]              kv_rdata;

  logic                         slot_empty;
  logic                         slot_hit;
  logic                         probe_stop;
  logic                         probe_exhausted;
  logic                         out_load;
  logic                         out_can_load;

  assign in_ready   = (state == S_IDLE);
  assign in_beat    = in_valid && in_ready;
  assign home_start = in_beat && (state_next == S_HASH);

  assign slot_empty = (st_rdata == SL_EMPTY);
  assign slot_hit   = (st_rdata == SL_OCCUPIED) && (kv_rdata[KV_W-1:VALUE_BITS] == key);
  assign probe_stop = slot_empty || slot_hit;
  assign probe_exhausted = !probe_stop && (probe_cnt == LAST_IDX);

  // memory writes happen at the compare step or during the clearing sweep
  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx;
    st_wdata = SL_EMPTY;
    kv_we    = 1'b0;
    if (state == S_CLR) begin
      st_we    = 1'b1;
      st_waddr = clr_idx;
    end else if (state == S_CHK && probe_stop) begin
      if (op == OP_INSERT) begin
        st_we    = 1'b1;
        st_wdata = SL_OCCUPIED;
        kv_we    = 1'b1;
      end else if (op == OP_DELETE && slot_hit) begin
        st_we    = 1'b1;
        st_wdata = SL_DELETED;
      end
    end
  end

  lph_ram #(
    .WIDTH(SLOT_BITS),
    .DEPTH(TABLE_SIZE)
  ) u_status_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(idx),
    .rdata(st_rdata)
  );

  lph_ram #(
    .WIDTH(KV_W),
    .DEPTH(TABLE_SIZE)
  ) u_kv_ram (
    .clk  (clk),
    .we   (kv_we),
    .waddr(idx),
    .wdata({key, val}),
    .raddr(idx),
    .rdata(kv_rdata)
  );

  lph_home #(
    .TABLE_SIZE(TABLE_SIZE),
    .KEY_BITS  (KEY_BITS)
  ) u_home (
    .clk  (clk),
    .rst  (rst),
    .start(home_start),
    .key  (lookup_key),
    .done (home_done),
    .idx  (home_idx)
  );

  assign out_load = (state == S_OUT);

  lph_outreg u_outreg (
    .clk        (clk),
    .rst        (rst),
    .load       (out_load),
    .load_status(res_status),
    .load_value (res_value),
    .can_load   (out_can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (clr_idx == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (opcode)
            OP_INSERT: state_next = (fill >= FILL_MAX) ? S_OUT : S_HASH;
            OP_SEARCH, OP_DELETE: state_next = S_HASH;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_HASH: begin
        if (home_done) state_next = S_RD;
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        state_next = (probe_stop || probe_exhausted) ? S_OUT : S_RD;
      end
      S_OUT: begin
        if (out_can_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
      fill    <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (kv_we) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  // item payload, result and probe position
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op         <= opcode;
      key        <= lookup_key;
      val        <= new_value;
      res_value  <= '0;
      res_status <= (opcode == OP_INSERT) ? RES_FULL : RES_NOT_FOUND;
    end
    if (state == S_HASH && home_done) begin
      idx       <= home_idx;
      probe_cnt <= '0;
    end
    if (state == S_CHK) begin
      if (probe_stop) begin
        if (op == OP_INSERT || slot_hit) begin
          res_status <= RES_OK;
        end else begin
          res_status <= RES_NOT_FOUND;
        end
        if (op == OP_SEARCH && slot_hit) begin
          res_value <= kv_rdata[VALUE_BITS-1:0];
        end
      end else if (!probe_exhausted) begin
        idx       <= (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
        probe_cnt <= probe_cnt + IDX_W'(1);
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("fill count above table size");

  a_delete_mark: assert property (@(posedge clk) disable iff (rst)
    (st_we && st_wdata == SL_DELETED) |-> (op == OP_DELETE && state == S_CHK))
    else $error("slot marked deleted outside a delete hit");

  a_home_done: assert property (@(posedge clk) disable iff (rst)
    home_done |-> state == S_HASH)
    else $error("home slot ready outside hashing step");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_can_load) |=> (out_valid && state == S_IDLE))
    else $error("result beat lost after load");

endmodule

/* rtl/core/lph_ram.sv */
// generic single write port, single read port ram with registered read
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lph_home.sv */
// home slot unit: key modulo table size, a mask or a short reciprocal multiply pipeline
module lph_home import lph_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [KEY_BITS-1:0]           key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] idx
);

  localparam int  IDX_W  = $clog2(TABLE_SIZE);
  localparam int  EXT_W  = (KEY_BITS > IDX_W) ? KEY_BITS : IDX_W;
  localparam int  PROD_W = 2 * KEY_BITS;
  localparam int  RED_W  = EXT_W + 1;
  localparam bit  POW2   = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam logic [KEY_BITS-1:0] RECIP  = KEY_BITS'((64'd1 << KEY_BITS) / TABLE_SIZE);
  localparam logic [RED_W-1:0]    TS_RED = RED_W'(TABLE_SIZE);

  logic [EXT_W-1:0]    key_ext;
  logic [KEY_BITS-1:0] key_r;
  logic [PROD_W-1:0]   prod;
  logic [KEY_BITS-1:0] quo;
  logic [RED_W-1:0]    qts;
  logic [RED_W-1:0]    red;
  logic [IDX_W-1:0]    rem;
  logic                prod_vld;
  logic                red_vld;

  // quotient estimate is exact or one low, so one correction step is enough
  assign key_ext = EXT_W'(key);
  assign quo     = prod[PROD_W-1:KEY_BITS];
  assign qts     = RED_W'(quo) * TS_RED;
  assign idx     = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      red_vld  <= 1'b0;
      done     <= 1'b0;
    end else begin
      prod_vld <= start && !POW2;
      red_vld  <= prod_vld;
      done     <= (start && POW2) || red_vld;
    end
  end

  // remainder datapath
  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
      prod  <= PROD_W'(key) * PROD_W'(RECIP);
    end
    if (prod_vld) begin
      red <= RED_W'(key_r) - qts;
    end
    if (start && POW2) begin
      rem <= key_ext[IDX_W-1:0];
    end else if (red_vld) begin
      rem <= (red >= TS_RED) ? IDX_W'(red - TS_RED) : red[IDX_W-1:0];
    end
  end

endmodule

/* rtl/core/lph_outreg.sv */
// result register between the probe engine and the output channel
module lph_outreg import lph_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [STATUS_BITS-1:0]       load_status,
  input  logic signed [VALUE_BITS-1:0] load_value,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [STATUS_BITS-1:0]       status,
  output logic signed [VALUE_BITS-1:0] read_value
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && can_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      status     <= load_status;
      read_value <= load_value;
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the linear probing hash table: directed and random operations
module testbench;
  import lph_pkg::*;

  localparam int SLOTS = TABLE_SIZE_DEF;
  localparam int KEYW = KEY_BITS_DEF;
  localparam int HOME_BITS = $clog2(SLOTS);
  localparam int SHOW_LIMIT = 10;
  localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

  typedef logic [KEYW-1:0] key_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef struct packed {
    logic [STATUS_BITS-1:0] code;
    value_t value;
  } reply_t;
  typedef enum {
    INS_NEW, INS_LIVE, INS_DEAD, FIND_LIVE, FIND_DEAD, FIND_ANY, DEL_LIVE, DEL_ANY, JUNK_OP
  } choice_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPCODE_BITS-1:0] opcode = OP_SEARCH;
  key_t lookup_key = '0;
  value_t new_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_BITS-1:0] status;
  value_t read_value;

  logic [SLOT_BITS-1:0] slot_state [SLOTS] = '{default: SL_EMPTY};
  key_t slot_key [SLOTS];
  value_t slot_val [SLOTS];
  int fill_count = 0;
  reply_t replies_due [$];
  reply_t head;
  int mismatches = 0;
  int burst_left = 0;
  int hold_left = 0;

  linear_probe_hash_table dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit probe_for(input key_t key, output int slot, output bit hit);
    int idx;
    idx = int'(key) % SLOTS;
    slot = 0;
    hit = 1'b0;
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_state[idx] == SL_EMPTY) begin
        slot = idx;
        return 1'b1;
      end
      if (slot_state[idx] == SL_OCCUPIED && slot_key[idx] == key) begin
        slot = idx;
        hit = 1'b1;
        return 1'b1;
      end
      idx = (idx + 1) % SLOTS;
    end
    return 1'b0;
  endfunction

  function automatic reply_t apply_op(input logic [OPCODE_BITS-1:0] op, input key_t key,
                                      input value_t val);
    reply_t r;
    int slot;
    bit hit;
    r.code = RES_NOT_FOUND;
    r.value = '0;
    case (op)
      OP_INSERT: begin
        if (fill_count >= SLOTS || !probe_for(key, slot, hit)) begin
          r.code = RES_FULL;
        end else begin
          slot_key[slot] = key;
          slot_val[slot] = val;
          slot_state[slot] = SL_OCCUPIED;
          fill_count++;
          r.code = RES_OK;
        end
      end
      OP_SEARCH: begin
        if (probe_for(key, slot, hit) && hit) begin
          r.code = RES_OK;
          r.value = slot_val[slot];
        end
      end
      OP_DELETE: begin
        if (probe_for(key, slot, hit) && hit) begin
          slot_state[slot] = SL_DELETED;
          r.code = RES_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display("mismatch in %s: expected %h, got %h at %0t ns", what, want, got, $time);
  endtask

  task automatic send_op(input logic [OPCODE_BITS-1:0] op, input key_t key, input value_t val);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    opcode <= op;
    lookup_key <= key;
    new_value <= val;
    in_valid <= 1'b1;
    replies_due.insert(replies_due.size(), apply_op(op, key, val));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_replies();
    if (in_valid) in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // receiver: long ready stretches broken by short stalls
  always @(posedge clk) begin
    if (hold_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(1, 8);
      end else begin
        out_ready <= 1'b1;
        hold_left <= $urandom_range(1, 40);
      end
    end else begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        flag("result beat with none outstanding", '0, 32'(status));
      end else begin
        head = replies_due.pop_front();
        if (status !== head.code) flag("result code", 32'(head.code), 32'(status));
        if (read_value !== head.value) flag("read value", head.value, read_value);
      end
    end
  end

  // keys cluster near the top and bottom slots at times, to force wrap and long probe chains
  function automatic key_t any_key();
    key_t k;
    k = key_t'($urandom);
    if ($urandom_range(0, 3) == 0)
      k[HOME_BITS-1:0] = HOME_BITS'((SLOTS - 14 + $urandom_range(0, 30)) % SLOTS);
    return k;
  endfunction

  function automatic key_t stored_key(input logic [SLOT_BITS-1:0] want);
    int idx;
    idx = $urandom_range(0, SLOTS - 1);
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_state[idx] == want) return slot_key[idx];
      idx = (idx + 1) % SLOTS;
    end
    return any_key();
  endfunction

  function automatic choice_t draw_choice(input bit full);
    int pick;
    pick = $urandom_range(0, 99);
    if (!full) begin
      if (pick < 75) return INS_NEW;
      if (pick < 80) return INS_LIVE;
      if (pick < 85) return INS_DEAD;
      if (pick < 90) return FIND_LIVE;
      if (pick < 91) return FIND_DEAD;
      if (pick < 93) return FIND_ANY;
      if (pick < 97) return DEL_LIVE;
      if (pick < 99) return DEL_ANY;
      return JUNK_OP;
    end
    if (pick < 15) return INS_NEW;
    if (pick < 25) return INS_LIVE;
    if (pick < 30) return INS_DEAD;
    if (pick < 60) return FIND_LIVE;
    if (pick < 70) return FIND_DEAD;
    if (pick < 80) return FIND_ANY;
    if (pick < 90) return DEL_LIVE;
    if (pick < 95) return DEL_ANY;
    return JUNK_OP;
  endfunction

  task automatic random_op(input bit full);
    choice_t c;
    c = draw_choice(full);
    if ($urandom_range(0, 99) == 0) wait_for_replies();
    case (c)
      INS_NEW:   send_op(OP_INSERT, any_key(), value_t'($urandom));
      INS_LIVE:  send_op(OP_INSERT, stored_key(SL_OCCUPIED), value_t'($urandom));
      INS_DEAD:  send_op(OP_INSERT, stored_key(SL_DELETED), value_t'($urandom));
      FIND_LIVE: send_op(OP_SEARCH, stored_key(SL_OCCUPIED), value_t'($urandom));
      FIND_DEAD: send_op(OP_SEARCH, stored_key(SL_DELETED), value_t'($urandom));
      FIND_ANY:  send_op(OP_SEARCH, any_key(), value_t'($urandom));
      DEL_LIVE:  send_op(OP_DELETE, stored_key(SL_OCCUPIED), value_t'($urandom));
      DEL_ANY:   send_op(OP_DELETE, any_key(), value_t'($urandom));
      default:   send_op(OP_UNUSED, any_key(), value_t'($urandom));
    endcase
  endtask

  task automatic test_empty_table();
    send_op(OP_SEARCH, 20'h00000, 32'h0000_0000);
    send_op(OP_DELETE, 20'hFFFFF, 32'hFFFF_FFFF);
    send_op(OP_UNUSED, 20'h00005, 32'hFFFF_FFFF);
  endtask

  task automatic test_collisions_and_wrap();
    send_op(OP_INSERT, 20'h00000, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 20'hFFFFF, 32'h8000_0000);
    send_op(OP_INSERT, 20'h003FF, 32'h1234_5678);
    send_op(OP_SEARCH, 20'h003FF, 32'h0000_0000);
    send_op(OP_SEARCH, 20'hFFFFF, 32'h0000_0000);
    send_op(OP_SEARCH, 20'h00000, 32'h0000_0000);
    send_op(OP_SEARCH, 20'h007FF, 32'h0000_0000);
  endtask

  task automatic test_delete_and_reinsert();
    send_op(OP_DELETE, 20'hFFFFF, 32'h0000_0000);
    send_op(OP_SEARCH, 20'h003FF, 32'h0000_0000);
    send_op(OP_SEARCH, 20'hFFFFF, 32'h0000_0000);
    send_op(OP_DELETE, 20'hFFFFF, 32'h0000_0000);
    send_op(OP_INSERT, 20'hFFFFF, 32'hFFFF_FFFF);
    send_op(OP_SEARCH, 20'hFFFFF, 32'h0000_0000);
    send_op(OP_UNUSED, 20'hFFFFF, 32'h0000_0001);
  endtask

  task automatic test_overwrite_and_patterns();
    send_op(OP_INSERT, 20'h00000, 32'h0000_0000);
    send_op(OP_SEARCH, 20'h00000, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 20'hAAAAA, 32'hAAAA_AAAA);
    send_op(OP_INSERT, 20'h55555, 32'h5555_5555);
    send_op(OP_SEARCH, 20'hAAAAA, 32'h0000_0000);
    send_op(OP_SEARCH, 20'h55555, 32'h0000_0000);
    send_op(OP_DELETE, 20'h00000, 32'h0000_0000);
    send_op(OP_DELETE, 20'h00000, 32'h0000_0000);
  endtask

  task automatic test_random_fill();
    for (int n = 0; n < 4000 && fill_count < SLOTS; n++) random_op(1'b0);
  endtask

  task automatic test_full_table();
    repeat (80) random_op(1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_collisions_and_wrap();
    test_delete_and_reinsert();
    test_overwrite_and_patterns();
    wait_for_replies();
    test_random_fill();
    wait_for_replies();
    test_full_table();
    wait_for_replies();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
